@@ sv/suffix_automaton_builder_assert.svh @@
// Assertion helpers used by the RTL file sv/sab_dp.sv.
`ifndef SUFFIX_AUTOMATON_BUILDER_ASSERT_SVH
`define SUFFIX_AUTOMATON_BUILDER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define SAB_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("sab assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define SAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sab assertion failed");

`endif

@@ sv/sab_pkg.sv @@
`default_nettype none
package sab_pkg;
  localparam int MAX_STATES = 4096;
  localparam int ALPHABET   = 26;
  localparam int ST_W       = $clog2(MAX_STATES);
  localparam int CNT_W      = ST_W + 1;
  localparam int LEN_W      = ST_W;
  localparam int SYM_W      = 5;

  localparam logic [CNT_W-1:0] NO_LINK = CNT_W'(MAX_STATES);

  typedef logic [ALPHABET-1:0][ST_W-1:0] row_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_FULL,
    OP_NEW,
    OP_LEN,
    OP_STEP,
    OP_ROOTLINK,
    OP_FOUND,
    OP_LINKQ,
    OP_CLONE,
    OP_LINK_NP_CL,
    OP_LINK_Q_CL,
    OP_REDIR,
    OP_COMMIT,
    OP_QSTART,
    OP_QREAD,
    OP_QMISS,
    OP_QSTEP,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic kind;
    logic start;
    logic sym_ok;
    logic room;
    logic edge_zero;
    logic edge_is_q;
    logic link_none;
    logic len_match;
    logic missed;
    logic out_free;
  } dp_status_t;
endpackage
`default_nettype wire

@@ sv/sab_if.sv @@
`default_nettype none
interface sab_in_if import sab_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [SYM_W-1:0] symbol;
  logic             start_req;

  modport source (output valid, kind, symbol, start_req, input ready);
  modport sink   (input valid, kind, symbol, start_req, output ready);
endinterface

interface sab_out_if import sab_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  state_index;
  logic [CNT_W-1:0] state_count;
  logic             found;
  logic             full_res;

  modport source (output valid, state_index, state_count, found, full_res, input ready);
  modport sink   (input valid, state_index, state_count, found, full_res, output ready);
endinterface
`default_nettype wire

@@ sv/sab_dp.sv @@
`default_nettype none
`include "suffix_automaton_builder_assert.svh"
module sab_dp import sab_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_op_e           op_i,
  input  wire logic             kind_i,
  input  wire logic [SYM_W-1:0] symbol_i,
  input  wire logic             start_i,
  input  wire logic             out_ready_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  output logic [ST_W-1:0]       state_index_o,
  output logic [CNT_W-1:0]      state_count_o,
  output logic                  found_o,
  output logic                  full_res_o
);
  // state memories, one row of edges per state
  row_t             trans_mem [MAX_STATES];
  logic [CNT_W-1:0] link_mem  [MAX_STATES];
  logic [LEN_W-1:0] len_mem   [MAX_STATES];

  row_t             row_rd;
  logic [CNT_W-1:0] link_rd;
  logic [LEN_W-1:0] len_rd;

  logic [CNT_W-1:0] used_q, used_d;
  logic [ST_W-1:0]  last_q, last_d, walk_q, walk_d;
  logic             missed_q, missed_d, out_valid_q, out_valid_d;
  logic [ST_W-1:0]  np_q, p_q, q_q, cl_q;
  logic [LEN_W-1:0] lenp_q;
  logic [SYM_W-1:0] c_q;
  logic             kind_q, start_q, full_q;
  logic [ST_W-1:0]  idx_q;
  logic [CNT_W-1:0] cnt_q;
  logic             found_q, fullr_q;

  logic [ST_W-1:0]  rd_addr, edge_tgt, used_idx;
  row_t             row_mod;
  logic             t_we, l_we, n_we;
  logic [ST_W-1:0]  t_wa, l_wa, n_wa;
  row_t             t_wd;
  logic [CNT_W-1:0] l_wd;
  logic [LEN_W-1:0] n_wd;

  assign used_idx = used_q[ST_W-1:0];
  assign edge_tgt = row_rd[c_q];

  always_comb begin
    row_mod = row_rd;
    row_mod[c_q] = (op_i == OP_REDIR) ? cl_q : np_q;
  end

  always_comb begin
    unique case (op_i)
      OP_NEW:                 rd_addr = last_q;
      OP_STEP, OP_REDIR:      rd_addr = link_rd[ST_W-1:0];
      OP_FOUND:               rd_addr = edge_tgt;
      OP_QREAD:               rd_addr = walk_q;
      default:                rd_addr = p_q;
    endcase
  end

  always_comb begin
    t_we = 1'b0; t_wa = '0; t_wd = '0;
    l_we = 1'b0; l_wa = '0; l_wd = '0;
    n_we = 1'b0; n_wa = '0; n_wd = '0;
    unique case (op_i)
      OP_CLEAR: begin
        t_we = 1'b1;
        l_we = 1'b1; l_wd = NO_LINK;
        n_we = 1'b1;
      end
      OP_NEW: begin
        t_we = 1'b1; t_wa = used_idx;
      end
      OP_LEN: begin
        n_we = 1'b1; n_wa = np_q; n_wd = len_rd + 1'b1;
      end
      OP_STEP, OP_REDIR: begin
        t_we = 1'b1; t_wa = p_q; t_wd = row_mod;
      end
      OP_ROOTLINK: begin
        l_we = 1'b1; l_wa = np_q;
      end
      OP_LINKQ: begin
        l_we = 1'b1; l_wa = np_q; l_wd = {1'b0, q_q};
      end
      OP_CLONE: begin
        t_we = 1'b1; t_wa = used_idx; t_wd = row_rd;
        l_we = 1'b1; l_wa = used_idx; l_wd = link_rd;
        n_we = 1'b1; n_wa = used_idx; n_wd = lenp_q + 1'b1;
      end
      OP_LINK_NP_CL: begin
        l_we = 1'b1; l_wa = np_q; l_wd = {1'b0, cl_q};
      end
      OP_LINK_Q_CL: begin
        l_we = 1'b1; l_wa = q_q; l_wd = {1'b0, cl_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (t_we) trans_mem[t_wa] <= t_wd;
    if (l_we) link_mem[l_wa] <= l_wd;
    if (n_we) len_mem[n_wa] <= n_wd;
    row_rd  <= trans_mem[rd_addr];
    link_rd <= link_mem[rd_addr];
    len_rd  <= len_mem[rd_addr];
  end

  always_comb begin
    used_d      = used_q;
    last_d      = last_q;
    walk_d      = walk_q;
    missed_d    = missed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (op_i)
      OP_CLEAR: begin
        used_d = CNT_W'(1); last_d = '0; walk_d = '0; missed_d = 1'b0;
      end
      OP_NEW, OP_CLONE: used_d = used_q + 1'b1;
      OP_COMMIT:        last_d = np_q;
      OP_QSTART: begin
        walk_d = '0; missed_d = 1'b0;
      end
      OP_QMISS:         missed_d = 1'b1;
      OP_QSTEP: begin
        if (edge_tgt != '0) walk_d = edge_tgt;
        else missed_d = 1'b1;
      end
      OP_OUT:           out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= CNT_W'(1);
      last_q      <= '0;
      walk_q      <= '0;
      missed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      used_q      <= used_d;
      last_q      <= last_d;
      walk_q      <= walk_d;
      missed_q    <= missed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_LOAD: begin
        kind_q <= kind_i; c_q <= symbol_i; start_q <= start_i; full_q <= 1'b0;
      end
      OP_FULL:  full_q <= 1'b1;
      OP_NEW: begin
        np_q <= used_idx; p_q <= last_q;
      end
      OP_STEP, OP_REDIR: p_q <= link_rd[ST_W-1:0];
      OP_FOUND: begin
        q_q <= edge_tgt; lenp_q <= len_rd;
      end
      OP_CLONE: cl_q <= used_idx;
      OP_OUT: begin
        cnt_q <= used_q;
        if (!kind_q) begin
          idx_q <= last_q; found_q <= 1'b0; fullr_q <= full_q;
        end else begin
          idx_q <= walk_q; found_q <= !missed_q; fullr_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.kind      = kind_q;
    status_o.start     = start_q;
    status_o.sym_ok    = c_q < SYM_W'(ALPHABET);
    status_o.room      = used_q <= CNT_W'(MAX_STATES - 2);
    status_o.edge_zero = edge_tgt == '0;
    status_o.edge_is_q = edge_tgt == q_q;
    status_o.link_none = link_rd == NO_LINK;
    status_o.len_match = (lenp_q + 1'b1) == len_rd;
    status_o.missed    = missed_q;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign state_index_o = idx_q;
  assign state_count_o = cnt_q;
  assign found_o       = found_q;
  assign full_res_o    = fullr_q;

  `SAB_ASSERT(a_used_range, (used_q >= CNT_W'(1)) && (used_q <= CNT_W'(MAX_STATES)))
  `SAB_ASSERT(a_ptrs_live, ({1'b0, last_q} < used_q) && ({1'b0, walk_q} < used_q))
  `SAB_ASSERT_NEXT(a_clone_bumps, op_i == OP_CLONE, used_q == $past(used_q) + 1'b1)
endmodule
`default_nettype wire

@@ sv/sab_ctrl.sv @@
`default_nettype none
module sab_ctrl import sab_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_op_e          op_o
);
  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISP, S_APP_CHK, S_LEN, S_WALK, S_ROOTLINK, S_CMP,
    S_LNP, S_LQ, S_REDIR, S_COMMIT, S_Q, S_QSTEP, S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    op_o    = OP_NONE;
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        op_o = OP_CLEAR; state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o = OP_LOAD; state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (!status_i.kind) begin
          if (status_i.start) op_o = OP_CLEAR;
          state_d = S_APP_CHK;
        end else begin
          if (status_i.start) op_o = OP_QSTART;
          state_d = S_Q;
        end
      end
      S_APP_CHK: begin
        priority if (!status_i.sym_ok) state_d = S_OUT;
        else if (!status_i.room) begin
          op_o = OP_FULL; state_d = S_OUT;
        end else begin
          op_o = OP_NEW; state_d = S_LEN;
        end
      end
      S_LEN: begin
        op_o = OP_LEN; state_d = S_WALK;
      end
      S_WALK: begin
        // missing edge: add it and follow the link; else the walk stops at q
        if (status_i.edge_zero) begin
          op_o = OP_STEP;
          if (status_i.link_none) state_d = S_ROOTLINK;
        end else begin
          op_o = OP_FOUND; state_d = S_CMP;
        end
      end
      S_ROOTLINK: begin
        op_o = OP_ROOTLINK; state_d = S_COMMIT;
      end
      S_CMP: begin
        if (status_i.len_match) begin
          op_o = OP_LINKQ; state_d = S_COMMIT;
        end else begin
          op_o = OP_CLONE; state_d = S_LNP;
        end
      end
      S_LNP: begin
        op_o = OP_LINK_NP_CL; state_d = S_LQ;
      end
      S_LQ: begin
        op_o = OP_LINK_Q_CL; state_d = S_REDIR;
      end
      S_REDIR: begin
        if (status_i.edge_is_q) begin
          op_o = OP_REDIR;
          if (status_i.link_none) state_d = S_COMMIT;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        op_o = OP_COMMIT; state_d = S_OUT;
      end
      S_Q: begin
        priority if (status_i.missed) state_d = S_OUT;
        else if (!status_i.sym_ok) begin
          op_o = OP_QMISS; state_d = S_OUT;
        end else begin
          op_o = OP_QREAD; state_d = S_QSTEP;
        end
      end
      S_QSTEP: begin
        op_o = OP_QSTEP; state_d = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          op_o = OP_OUT; state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

@@ sv/suffix_automaton_builder.sv @@
`default_nettype none
// Channel  Dir  Payload                                       Request moves
// in_i     in   kind, symbol, start_req                       one symbol or walk step
// out_o    out  state_index, state_count, found, full_res     one result per request
//
// One request at a time. A query reads the walk state's edge and steps along it, but not
// after a miss or with an out-of-range symbol. Ignored or full appends add no state.
// An append adds an edge at each state on the suffix-link walk; if the walk stops at
// an existing edge it links to that target or clones it and runs the redirect checks.
// After reset the init state writes the root row before the first request is taken.
// A stalled result is held in the output register; the next result waits for it.
module suffix_automaton_builder import sab_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  sab_in_if.sink   in_i,
  sab_out_if.source out_o
);
  dp_op_e     op;
  dp_status_t status;

  sab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .op_o       (op)
  );

  sab_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .kind_i        (in_i.kind),
    .symbol_i      (in_i.symbol),
    .start_i       (in_i.start_req),
    .out_ready_i   (out_o.ready),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .state_index_o (out_o.state_index),
    .state_count_o (out_o.state_count),
    .found_o       (out_o.found),
    .full_res_o    (out_o.full_res)
  );
endmodule
`default_nettype wire

@@ bench/sab_tb_if.sv @@
`timescale 1ns / 1ps
// Interfaces come from the RTL file sv/sab_if.sv; nothing extra is needed here.
// This file keeps the bench's local parameters shared by the top module.
package sab_tb_pkg;
  import sab_pkg::*;
  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 500;
  localparam int IDLE_LIMIT    = 20000;
endpackage

@@ bench/suffix_automaton_builder_tb.sv @@
`timescale 1ns / 1ps
module suffix_automaton_builder_tb;
  import sab_pkg::*;
  import sab_tb_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [SYM_W-1:0] symbol;
    logic             start_req;
  } sym_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  state_index;
    logic [CNT_W-1:0] state_count;
    logic             found;
    logic             full_res;
  } sam_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  sab_in_if  in_ch ();
  sab_out_if out_ch ();

  suffix_automaton_builder u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predictor state
  int unsigned trans_q[MAX_STATES][ALPHABET];
  int unsigned link_q[MAX_STATES];
  int unsigned len_q[MAX_STATES];
  int unsigned n_states, last_st, walk_pos;
  bit walk_miss;

  sam_res_t expected_res[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  bit       no_idle = 1'b0;
  bit       sink_hold = 1'b0;

  function automatic void sam_clear();
    for (int a = 0; a < ALPHABET; a++) trans_q[0][a] = 0;
    link_q[0] = MAX_STATES;
    len_q[0] = 0;
    n_states = 1;
    last_st = 0;
    walk_pos = 0;
    walk_miss = 1'b0;
  endfunction

  function automatic void sam_extend(int unsigned c);
    int unsigned np, p, q, cl;
    np = n_states;
    p = last_st;
    n_states++;
    for (int a = 0; a < ALPHABET; a++) trans_q[np][a] = 0;
    len_q[np] = len_q[p] + 1;
    while (p != MAX_STATES && trans_q[p][c] == 0) begin
      trans_q[p][c] = np;
      p = link_q[p];
    end
    if (p == MAX_STATES) begin
      link_q[np] = 0;
    end else begin
      q = trans_q[p][c];
      if (len_q[p] + 1 == len_q[q]) begin
        link_q[np] = q;
      end else begin
        cl = n_states;
        n_states++;
        len_q[cl] = len_q[p] + 1;
        for (int a = 0; a < ALPHABET; a++) trans_q[cl][a] = trans_q[q][a];
        link_q[cl] = link_q[q];
        link_q[np] = cl;
        link_q[q] = cl;
        while (p != MAX_STATES && trans_q[p][c] == q) begin
          trans_q[p][c] = cl;
          p = link_q[p];
        end
      end
    end
    last_st = np;
  endfunction

  function automatic sam_res_t sam_predict(sym_req_t r);
    sam_res_t    res;
    int unsigned nx;
    res = '0;
    if (r.kind == 1'b0) begin
      if (r.start_req) sam_clear();
      if (r.symbol < ALPHABET) begin
        if (n_states + 2 <= MAX_STATES) sam_extend(r.symbol);
        else res.full_res = 1'b1;
      end
      res.state_index = last_st[ST_W-1:0];
    end else begin
      if (r.start_req) begin
        walk_pos = 0;
        walk_miss = 1'b0;
      end
      if (!walk_miss) begin
        nx = 0;
        if (r.symbol < ALPHABET) nx = trans_q[walk_pos][r.symbol];
        if (nx != 0) walk_pos = nx;
        else walk_miss = 1'b1;
      end
      res.found = !walk_miss;
      res.state_index = walk_pos[ST_W-1:0];
    end
    res.state_count = n_states[CNT_W-1:0];
    return res;
  endfunction

  // directed rows; typed expectations where obvious, else predictor
  sym_req_t dir_req[DIRECTED_ROWS];
  sam_res_t dir_res[DIRECTED_ROWS];
  bit       dir_typed[DIRECTED_ROWS];

  task automatic set_row(int i, logic k, int s, logic st, bit typed, sam_res_t r);
    dir_req[i] = '{kind: k, symbol: SYM_W'(s), start_req: st};
    dir_typed[i] = typed;
    dir_res[i] = r;
  endtask

  initial begin
    // query after reset: root has no edge
    set_row(0, 1, 0, 1, 1, '{state_index: 0, state_count: 1, found: 0, full_res: 0});
    set_row(1, 0, 0, 1, 1, '{state_index: 1, state_count: 2, found: 0, full_res: 0});
    set_row(2, 0, 25, 0, 0, '0);
    set_row(3, 0, 0, 0, 0, '0);
    set_row(4, 0, 0, 0, 0, '0);
    set_row(5, 0, 25, 0, 0, '0);
    set_row(6, 0, 31, 0, 0, '0);  // out-of-range append ignored
    set_row(7, 1, 0, 1, 1, '{state_index: 1, state_count: 6, found: 1, full_res: 0});
    set_row(8, 1, 0, 0, 0, '0);
    set_row(9, 1, 25, 0, 0, '0);
    set_row(10, 1, 31, 0, 0, '0); // out-of-range query misses
    set_row(11, 1, 0, 0, 0, '0);  // sticky
    set_row(12, 1, 25, 1, 0, '0);
    set_row(13, 0, 30, 1, 1, '{state_index: 0, state_count: 1, found: 0, full_res: 0});
    set_row(14, 1, 30, 1, 1, '{state_index: 0, state_count: 1, found: 0, full_res: 0});
    set_row(15, 0, 1, 0, 0, '0);
    set_row(16, 0, 2, 0, 0, '0);
    set_row(17, 0, 1, 0, 0, '0);
    set_row(18, 0, 2, 0, 0, '0);
    set_row(19, 1, 2, 1, 0, '0);
    set_row(20, 1, 1, 0, 0, '0);
    set_row(21, 1, 2, 0, 0, '0);
  end

  task automatic send_req(sym_req_t r, bit typed, sam_res_t tr);
    sam_res_t p;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= r.kind;
    in_ch.symbol    <= r.symbol;
    in_ch.start_req <= r.start_req;
    do @(posedge clk_i); while (!in_ch.ready);
    p = sam_predict(r);
    expected_res.push_back(typed ? tr : p);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_res.size() != 0) @(posedge clk_i);
  endtask

  // random item: mostly appends over 2, 4 or all ALPHABET symbols by phase, and walks of text
  function automatic sym_req_t rand_req(int phase);
    sym_req_t r;
    int       alpha;
    alpha = (phase % 3 == 0) ? 2 : ((phase % 3 == 1) ? 4 : ALPHABET);
    r.kind = ($urandom_range(0, 2) == 0);
    r.symbol = SYM_W'($urandom_range(0, alpha - 1));
    if ($urandom_range(0, 40) == 0) r.symbol = SYM_W'($urandom_range(0, 31));
    r.start_req = r.kind ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 60) == 0);
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.symbol = '0;
    in_ch.start_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sam_clear();
    for (int i = 0; i < DIRECTED_ROWS; i++) send_req(dir_req[i], dir_typed[i], dir_res[i]);
    drain();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) begin
        sink_hold = 1'b1;
      end
      if (i == 250) drain();
      if (i == 420) no_idle = 1'b1;
      send_req(rand_req(i / 60), 1'b0, '0);
    end
    drain();
    stim_done = 1'b1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        sink_hold = 1'b0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sam_res_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{state_index: out_ch.state_index, state_count: out_ch.state_count,
              found: out_ch.found, full_res: out_ch.full_res};
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_res.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d cnt %0d found %0b full %0b, got %0d %0d %0b %0b",
                     want.state_index, want.state_count, want.found, want.full_res,
                     got.state_index, got.state_count, got.found, got.full_res);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || sink_hold)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done || idle_cycles >= IDLE_LIMIT);
    if (!stim_done) begin
      $display("status: fail");
    end else begin
      repeat (100) @(posedge clk_i);
      if (mismatches == 0 && expected_res.size() == 0) $display("status: pass");
      else $display("status: fail");
    end
    $finish;
  end
endmodule
